// ===== hdl/fmavg_pkg.sv =====
package fmavg_pkg;

   localparam int WINDOW_MAX_DEFAULT  = 40;
   localparam int SAMPLE_BITS_DEFAULT = 24;

   localparam int SETTING_BITS = 7;
   localparam logic [SETTING_BITS-1:0] SETTING_MAX   = 7'd100;
   localparam logic [SETTING_BITS-1:0] SETTING_RESET = 7'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   // decade settings 0 to 90 pick the window, anything else is a window of one
   function automatic logic [SETTING_BITS-1:0] table_length(
      input logic [SETTING_BITS-1:0] setting
   );
      logic [SETTING_BITS-1:0] len;
      unique case (setting)
         7'd0:    len = 7'd40;
         7'd10:   len = 7'd35;
         7'd20:   len = 7'd30;
         7'd30:   len = 7'd25;
         7'd40:   len = 7'd20;
         7'd50:   len = 7'd15;
         7'd60:   len = 7'd10;
         7'd70:   len = 7'd7;
         7'd80:   len = 7'd4;
         7'd90:   len = 7'd2;
         default: len = 7'd1;
      endcase
      return len;
   endfunction

endpackage

// ===== hdl/fmavg_div.sv =====
module fmavg_div import fmavg_pkg::*; #(
   parameter int SUM_BITS = SAMPLE_BITS_DEFAULT + 6,
   parameter int LEN_BITS = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_BITS-1:0] dividend,
   input  logic        [LEN_BITS-1:0] divisor,
   output logic                       done,
   output logic signed [SUM_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(SUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [SUM_BITS-1:0] quo_ff, quo_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic [LEN_BITS:0]   shifted;
   logic [LEN_BITS:0]   diff;
   logic                fits;

   // restoring division on the magnitude, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_BITS-1]};
      fits    = shifted >= {1'b0, divisor};
      diff    = shifted - {1'b0, divisor};

      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;

      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_BITS-1];
         quo_in  = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(SUM_BITS);
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_BITS-2:0], fits};
         rem_in = fits ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   // truncation toward zero: divide the magnitude, then restore the sign
   assign quotient = neg_ff ? $signed(~quo_ff + 1'b1) : $signed(quo_ff);
   assign done     = done_ff;

endmodule

// ===== hdl/force_moving_average.sv =====
// Boxcar moving average over signed force samples. Each transaction on the
// req_ side is one sample; exactly one average comes back on the rsp_ side,
// the window sum divided by the window length and truncated toward zero.
// csr_write_data (0 to 100) picks the window length from the decade table,
// any other value gives a window of one; a write that changes the setting
// empties the window, and a write beyond 100 or of the same value is ignored.
// Write it only while no sample is in flight. An accepted sample passes
// through ST_SUM for the sample memory read and sum update, ST_LOAD to
// load the divider, and ST_DIV, where the single restoring divider works
// through the sum bit by bit and sets the rate; ST_DONE then loads the
// result into the output register. req_ready is low from acceptance until
// the result is loaded, and a new sample may be taken while the previous
// result waits on rsp_ready. Stored samples are cleared at once by
// per-entry valid flags, so there is no clearing pass after reset.
module force_moving_average import fmavg_pkg::*; #(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_force_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_average_force,
   input  logic                          csr_write_enable,
   input  logic        [SETTING_BITS-1:0] csr_write_data
);

   localparam int PTR_BITS = $clog2(WINDOW_MAX);
   localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX);
   localparam int EXT_BITS = SUM_BITS - SAMPLE_BITS;

   function automatic logic [LEN_BITS-1:0] window_for(
      input logic [SETTING_BITS-1:0] setting
   );
      logic [SETTING_BITS-1:0] len;
      len = table_length(setting);
      if (len > SETTING_BITS'(WINDOW_MAX)) begin
         len = SETTING_BITS'(WINDOW_MAX);
      end
      return len[LEN_BITS-1:0];
   endfunction

   state_type                      state_ff, state_in;
   logic [SETTING_BITS-1:0]        setting_ff, setting_in;
   logic [LEN_BITS-1:0]            len_ff, len_in;
   logic [PTR_BITS-1:0]            ptr_ff, ptr_in;
   logic signed [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [WINDOW_MAX-1:0]          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]  rsp_data_ff, rsp_data_in;

   logic signed [SAMPLE_BITS-1:0]  ring_mem [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0]  rd_ff;

   logic signed [SAMPLE_BITS-1:0]  oldest;
   logic signed [SUM_BITS-1:0]     sum_next;
   logic [PTR_BITS:0]              ptr_inc;
   logic                           div_start;
   logic                           div_done;
   logic signed [SUM_BITS-1:0]     div_quotient;

   fmavg_div #(
      .SUM_BITS (SUM_BITS),
      .LEN_BITS (LEN_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (len_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // an entry not written since the last clear reads as zero
   assign oldest   = valid_ff[ptr_ff] ? rd_ff : '0;
   assign sum_next = sum_ff
                   - $signed({{EXT_BITS{oldest[SAMPLE_BITS-1]}}, oldest})
                   + $signed({{EXT_BITS{sample_ff[SAMPLE_BITS-1]}}, sample_ff});
   assign ptr_inc  = {1'b0, ptr_ff} + 1'b1;

   always_comb begin
      state_in     = state_ff;
      setting_in   = setting_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      sum_in       = sum_ff;
      valid_in     = valid_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sample_in = req_force_sample;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in           = sum_next;
            valid_in[ptr_ff] = 1'b1;
            ptr_in = (ptr_inc >= (PTR_BITS + 1)'(len_ff)) ? '0 : ptr_inc[PTR_BITS-1:0];
            state_in         = ST_LOAD;
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = div_quotient[SAMPLE_BITS-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a changed setting empties the window
      if (csr_write_enable && csr_write_data <= SETTING_MAX
          && csr_write_data != setting_ff) begin
         setting_in = csr_write_data;
         len_in     = window_for(csr_write_data);
         ptr_in     = '0;
         sum_in     = '0;
         valid_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         setting_ff   <= SETTING_RESET;
         len_ff       <= window_for(SETTING_RESET);
         ptr_ff       <= '0;
         sum_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         setting_ff   <= setting_in;
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sample store, read every cycle at the ring pointer
   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         ring_mem[ptr_ff] <= sample_ff;
      end
      rd_ff <= ring_mem[ptr_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average_force = rsp_data_ff;

endmodule

// ===== hdl/fmavg_check.sv =====
module fmavg_check import fmavg_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [SAMPLE_BITS-1:0] req_force_sample,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_average_force,
   input logic                          csr_write_enable,
   input logic        [SETTING_BITS-1:0] csr_write_data
);

   // a pending result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the transaction completed");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_average_force))
      else $error("rsp_average_force changed while stalled");

   // one sample at a time: busy right after a transaction is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high straight after a transaction");

   // a result cannot appear in the cycle after a sample is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early after a transaction");

endmodule

bind force_moving_average fmavg_check #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_fmavg_check (.*);

// ===== verif/force_moving_average_tb.sv =====
`timescale 1ns / 1ps

module force_moving_average_tb;
   import fmavg_pkg::*;

   localparam int SAMPLE_BITS = SAMPLE_BITS_DEFAULT;
   localparam int WINDOW_MAX  = WINDOW_MAX_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS = 400;

   localparam logic signed [SAMPLE_BITS-1:0] FORCE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] FORCE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_BITS-1:0] req_force_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_average_force;
   logic csr_write_enable = 1'b0;
   logic [SETTING_BITS-1:0] csr_write_data = '0;

   // predicted filter state
   logic signed [SAMPLE_BITS-1:0] window_store [WINDOW_MAX];
   longint window_sum;
   int unsigned slot;
   int unsigned window_len;
   logic [SETTING_BITS-1:0] filter_setting_q;

   logic signed [SAMPLE_BITS-1:0] pending_samples [$];
   logic signed [SAMPLE_BITS-1:0] pending_averages [$];

   int error_count = 0;
   int cycle_count = 0;
   int idle_odds = 0;
   int send_gap = 0;
   int take_gap = 0;
   // transactions handed to the driver and results taken back
   int issued_count = 0;
   int taken_count = 0;
   bit next_valid;

   always #6 clock = ~clock;

   force_moving_average dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_force_sample  (req_force_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_average_force (rsp_average_force),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   function automatic int unsigned window_for(input logic [SETTING_BITS-1:0] setting);
      int unsigned len;
      case (setting)
         7'd0:    len = 40;
         7'd10:   len = 35;
         7'd20:   len = 30;
         7'd30:   len = 25;
         7'd40:   len = 20;
         7'd50:   len = 15;
         7'd60:   len = 10;
         7'd70:   len = 7;
         7'd80:   len = 4;
         7'd90:   len = 2;
         default: len = 1;
      endcase
      if (len > WINDOW_MAX) len = WINDOW_MAX;
      return len;
   endfunction

   function automatic void empty_window();
      foreach (window_store[i]) window_store[i] = '0;
      window_sum = 0;
      slot = 0;
      window_len = window_for(filter_setting_q);
   endfunction

   // swap the oldest entry for the new sample and divide the running sum
   function automatic logic signed [SAMPLE_BITS-1:0] next_average(
      input logic signed [SAMPLE_BITS-1:0] force_in
   );
      longint quotient;
      if (slot >= window_len) slot = 0;
      window_sum -= longint'(window_store[slot]);
      window_store[slot] = force_in;
      window_sum += longint'(force_in);
      slot = (slot + 1 >= window_len) ? 0 : slot + 1;
      quotient = window_sum / longint'(window_len);
      return quotient[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] random_force();
      logic signed [SAMPLE_BITS-1:0] value;
      case ($urandom_range(0, 7))
         0:       value = FORCE_MAX;
         1:       value = FORCE_MIN;
         2:       value = SAMPLE_BITS'($signed($urandom_range(0, 31)) - 16);
         default: value = SAMPLE_BITS'($urandom());
      endcase
      return value;
   endfunction

   // sender side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            pending_averages.push_back(next_average(req_force_sample));
         if (!req_valid || req_ready) begin
            next_valid = 1'b0;
            if (send_gap != 0) begin
               send_gap--;
            end else if (idle_odds != 0 && $urandom_range(1, 16) <= idle_odds) begin
               send_gap = $urandom_range(0, 8);
            end else if (pending_samples.size() != 0) begin
               next_valid = 1'b1;
               issued_count++;
               req_force_sample <= pending_samples.pop_front();
            end
            req_valid <= next_valid;
         end
      end
   end

   // receiver side and checking
   always @(posedge clock) begin
      logic signed [SAMPLE_BITS-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            taken_count++;
            if (pending_averages.size() == 0) begin
               error_count++;
               $display("%0t: average %0d arrived with no transaction pending",
                        $time, rsp_average_force);
            end else begin
               want = pending_averages.pop_front();
               if (rsp_average_force !== want) begin
                  error_count++;
                  $display("%0t: average_force expected %0d actual %0d",
                           $time, want, rsp_average_force);
               end
            end
         end
         if (take_gap != 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, 16) <= idle_odds) begin
            take_gap = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic wait_idle();
      while (pending_samples.size() != 0 || issued_count != taken_count)
         @(posedge clock);
   endtask

   task automatic write_setting(input logic [SETTING_BITS-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      // out-of-range and repeated values leave the window alone
      if (value <= SETTING_MAX && value != filter_setting_q) begin
         filter_setting_q = value;
         empty_window();
      end
   endtask

   task automatic queue_force(input logic signed [SAMPLE_BITS-1:0] value);
      pending_samples.push_back(value);
   endtask

   initial begin
      int sent;
      int count;
      logic [SETTING_BITS-1:0] choice;
      filter_setting_q = SETTING_RESET;
      empty_window();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // window of one straight out of reset
      idle_odds = 3;
      queue_force('0);
      queue_force(24'sd1);
      queue_force(-24'sd1);
      queue_force(FORCE_MAX);
      queue_force(FORCE_MIN);
      queue_force(24'sh555555);
      queue_force(24'shAAAAAA);
      write_setting(SETTING_RESET);
      write_setting(7'd127);
      write_setting(7'd101);
      queue_force(24'sd5);

      // window of two: truncation toward zero on odd negative sums
      write_setting(7'd90);
      queue_force(FORCE_MAX);
      queue_force(FORCE_MAX);
      queue_force(FORCE_MIN);
      queue_force(FORCE_MIN);
      queue_force(24'sd3);
      queue_force(-24'sd4);
      write_setting(7'd90);
      queue_force(-24'sd1);

      // widest window
      write_setting(7'd0);
      queue_force(FORCE_MIN);
      queue_force(FORCE_MIN);
      queue_force(FORCE_MIN);
      queue_force(24'sd7);

      sent = 0;
      while (sent < RANDOM_ITEMS - 40) begin
         case ($urandom_range(0, 5))
            0, 1:    choice = 7'($urandom_range(0, 10) * 10);
            2:       choice = 7'($urandom_range(0, 127));
            3:       choice = filter_setting_q;
            4:       choice = $urandom_range(0, 1) ? 7'd0 : SETTING_MAX;
            default: choice = 7'($urandom_range(0, 9) * 10);
         endcase
         write_setting(choice);
         idle_odds = $urandom_range(0, 6);
         count = $urandom_range(5, 90);
         repeat (count) queue_force(random_force());
         sent += count;
      end

      // closing stretch with no idling on either side
      write_setting(7'd0);
      idle_odds = 0;
      repeat (40) queue_force(random_force());
      write_setting(SETTING_MAX);
      repeat (10) queue_force(random_force());

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== force_moving_average.f =====
hdl/fmavg_pkg.sv
hdl/fmavg_div.sv
hdl/force_moving_average.sv
hdl/fmavg_check.sv
verif/force_moving_average_tb.sv
